// File: sv/zhang_suen_thinning_pass_top_assert.svh
// Assertion macros shared by the checker of the thinning pass.
`ifndef ZHANG_SUEN_THINNING_PASS_TOP_ASSERT_SVH
`define ZHANG_SUEN_THINNING_PASS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZST_ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("thinning pass check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define ZST_ASSERT_NXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("thinning pass check failed (next cycle)");

`endif

// File: sv/zst_pkg.sv
// Types, constants and the removal test of the thinning pass.
package zst_pkg;

	localparam int CFG_W         = 11;
	localparam int ROW_W         = 11;
	localparam int COORD_W       = 10;
	localparam int IDX_W         = 2;
	localparam int MIN_DIM       = 3;
	localparam int MAX_HEIGHT    = 1024;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int WIDTH_RST     = 388;
	localparam int HEIGHT_RST    = 388;
	localparam int NEIGH_MIN     = 2;
	localparam int NEIGH_MAX     = 6;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_SUB_ITERATION = 2'd2;

	typedef struct packed {
		logic               px;
		logic               emit;
		logic               last;
		logic               interior;
		logic               sub;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} item_info_t;

	typedef struct packed {
		logic               pixel_out;
		logic               was_removed;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               last_of_frame;
		logic               frame_changed;
	} result_t;

	// Window bits: left column 0..2 (p9 p8 p7), centre 3..5 (p2 p1 p6),
	// right column 6..8 (p3 p4 p5).
	function automatic logic remove_f(input logic [8:0] win, input logic sub);
		logic [7:0] ring;
		logic [3:0] trans;
		logic [3:0] cnt;
		logic       m1;
		logic       m2;
		ring  = {win[0], win[1], win[2], win[5], win[8], win[7], win[6], win[3]};
		trans = 4'd0;
		cnt   = 4'd0;
		for (int k = 0; k < 8; k++) begin
			cnt = cnt + 4'(ring[k]);
			if (!ring[k] && ring[(k + 1) & 7])
				trans = trans + 4'd1;
		end
		if (!sub) begin
			m1 = ring[0] & ring[2] & ring[4];
			m2 = ring[2] & ring[4] & ring[6];
		end else begin
			m1 = ring[0] & ring[2] & ring[6];
			m2 = ring[0] & ring[4] & ring[6];
		end
		return win[4] && (trans == 4'd1) && (cnt >= 4'(NEIGH_MIN)) &&
			(cnt <= 4'(NEIGH_MAX)) && !m1 && !m2;
	endfunction

endpackage

// File: sv/zst_in_if.sv
// Input pixel channel of the thinning pass.
interface zst_in_if;
	logic valid;
	logic ready;
	logic pixel_in;
	logic is_padding;

	modport source (output valid, pixel_in, is_padding, input ready);
	modport sink (input valid, pixel_in, is_padding, output ready);
endinterface

// File: sv/zst_out_if.sv
// Result pixel channel of the thinning pass.
interface zst_out_if;
	logic                            valid;
	logic                            ready;
	logic                            pixel_out;
	logic                            was_removed;
	logic [zst_pkg::COORD_W-1:0]     out_row;
	logic [zst_pkg::COORD_W-1:0]     out_col;
	logic                            last_of_frame;
	logic                            frame_changed;

	modport source (output valid, pixel_out, was_removed, out_row, out_col,
		last_of_frame, frame_changed, input ready);
	modport sink (input valid, pixel_out, was_removed, out_row, out_col,
		last_of_frame, frame_changed, output ready);
endinterface

// File: sv/zst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module zst_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// File: sv/zst_ctrl.sv
// Configuration registers, raster position and per-item decisions.
module zst_ctrl #(
	parameter int MAX_WIDTH = zst_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [zst_pkg::IDX_W-1:0]     cfg_index,
	input  logic [zst_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          accept,
	input  logic                          pixel_in,
	input  logic                          is_padding,
	output logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
	output zst_pkg::item_info_t           info
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (WW > zst_pkg::CFG_W) ? WW : zst_pkg::CFG_W;
	localparam int RW = zst_pkg::ROW_W;

	logic [zst_pkg::CFG_W-1:0] width_q;
	logic [zst_pkg::CFG_W-1:0] height_q;
	logic                      sub_q;
	logic [RW-1:0]             row_q;
	logic [CW-1:0]             col_q;

	logic [XW-1:0] width_x;
	logic [XW-1:0] w;
	logic [XW-1:0] col_x;
	logic [XW-1:0] cc;
	logic [RW-1:0] h;
	logic [RW-1:0] cr;
	logic          col_nz;
	logic          last;
	logic          wrap;

	always_comb begin
		width_x = XW'(width_q);
		if (width_x < XW'(zst_pkg::MIN_DIM))
			w = XW'(zst_pkg::MIN_DIM);
		else if (width_x > XW'(MAX_WIDTH))
			w = XW'(MAX_WIDTH);
		else
			w = width_x;

		if (height_q < RW'(zst_pkg::MIN_DIM))
			h = RW'(zst_pkg::MIN_DIM);
		else if (height_q > RW'(zst_pkg::MAX_HEIGHT))
			h = RW'(zst_pkg::MAX_HEIGHT);
		else
			h = height_q;

		col_x  = XW'(col_q);
		col_nz = (col_q != '0);
		last   = ({1'b0, row_q} >= ({1'b0, h} + (RW + 1)'(1)));
		wrap   = (({1'b0, col_x} + (XW + 1)'(1)) >= {1'b0, w});

		// The first column of a row finishes the previous row's last pixel.
		cr = col_nz ? (row_q - RW'(1)) : (row_q - RW'(2));
		cc = col_nz ? (col_x - XW'(1)) : (w - XW'(1));

		info.px = (is_padding || (row_q >= h)) ? 1'b0 : pixel_in;
		info.emit = (row_q >= RW'(2)) || ((row_q == RW'(1)) && col_nz);
		info.last = last;
		info.interior = (cr != '0) && (({1'b0, cr} + (RW + 1)'(2)) <= {1'b0, h}) &&
			(cc != '0) && (({1'b0, cc} + (XW + 1)'(2)) <= {1'b0, w});
		info.sub = sub_q;
		info.row = cr[zst_pkg::COORD_W-1:0];
		info.col = cc[zst_pkg::COORD_W-1:0];
	end

	assign rd_col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= zst_pkg::CFG_W'(zst_pkg::WIDTH_RST);
			height_q <= zst_pkg::CFG_W'(zst_pkg::HEIGHT_RST);
			sub_q    <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					zst_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg_data;
					zst_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_data;
					zst_pkg::REG_SUB_ITERATION: sub_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				if (last) begin
					row_q <= '0;
					col_q <= '0;
				end else if (wrap) begin
					row_q <= row_q + RW'(1);
					col_q <= '0;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end
endmodule

// File: sv/zst_win.sv
// Line store, 3x3 window and the removal decision for one item.
module zst_win #(
	parameter int MAX_WIDTH = zst_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  zst_pkg::item_info_t          info,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
	output logic                         busy,
	output logic                         push,
	output zst_pkg::result_t             res
);
	localparam int CW = $clog2(MAX_WIDTH);

	logic                s1_valid_q;
	zst_pkg::item_info_t info_s1;
	logic [CW-1:0]       col_s1;
	logic [8:0]          window_q;
	logic                any_q;
	logic                fwd_q;
	logic [1:0]          fwd_data_q;

	logic [1:0] ram_rdata;
	logic [1:0] line;
	logic [1:0] wr_data;
	logic [8:0] win_next;
	logic       removed;
	logic       any_next;

	// Bit 0 holds the row two above, bit 1 the row above.
	zst_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (s1_valid_q),
		.waddr (col_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (rd_col),
		.rdata (ram_rdata)
	);

	always_comb begin
		// A read that met the write to the same column in that cycle saw old data.
		line     = fwd_q ? fwd_data_q : ram_rdata;
		wr_data  = {info_s1.px, line[1]};
		win_next = {info_s1.px, line[1], line[0], window_q[8:3]};
		removed  = info_s1.interior && zst_pkg::remove_f(win_next, info_s1.sub);
		any_next = any_q | removed;

		res.pixel_out     = win_next[4] & ~removed;
		res.was_removed   = removed;
		res.out_row       = info_s1.row;
		res.out_col       = info_s1.col;
		res.last_of_frame = info_s1.last;
		res.frame_changed = info_s1.last & any_next;
	end

	assign push = s1_valid_q && info_s1.emit;
	assign busy = s1_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			window_q   <= '0;
			any_q      <= 1'b0;
			fwd_q      <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			fwd_q      <= s1_valid_q && (rd_col == col_s1);
			if (s1_valid_q) begin
				window_q <= win_next;
				if (info_s1.emit)
					any_q <= info_s1.last ? 1'b0 : any_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_data;
		if (accept) begin
			info_s1 <= info;
			col_s1  <= rd_col;
		end
	end
endmodule

// File: sv/zst_outq.sv
// Three-entry result queue that decouples the pass from the consumer.
module zst_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  zst_pkg::result_t res,
	input  logic             pending,
	output logic             room,
	zst_out_if.source        out_ch
);
	localparam int DEPTH = 3;

	zst_pkg::result_t entry_q [DEPTH];
	logic [1:0]       count_q;
	logic [1:0]       wr_q;
	logic [1:0]       rd_q;
	logic             pop;
	zst_pkg::result_t head;

	function automatic logic [1:0] bump(input logic [1:0] p);
		return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	assign head = entry_q[rd_q];
	assign pop  = out_ch.valid && out_ch.ready;
	// Room is kept for the item still in the window stage.
	assign room = ({1'b0, count_q} + {2'b00, pending}) < 3'(DEPTH);

	assign out_ch.valid         = (count_q != 2'd0);
	assign out_ch.pixel_out     = head.pixel_out;
	assign out_ch.was_removed   = head.was_removed;
	assign out_ch.out_row       = head.out_row;
	assign out_ch.out_col       = head.out_col;
	assign out_ch.last_of_frame = head.last_of_frame;
	assign out_ch.frame_changed = head.frame_changed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
		end else begin
			if (push)
				wr_q <= bump(wr_q);
			if (pop)
				rd_q <= bump(rd_q);
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= res;
	end
endmodule

// File: sv/zhang_suen_thinning_pass_top.sv
// A result is held in the window stage, then written to the result queue, then offered.
// Throughput: one request per cycle while the queue has room, set by the line store's
// one read and one write per cycle, with a forward path when both hit the same column.
// Reset clears position, window, removal flag and result queue; the line store is
// not cleared, its stale entries only ever reach border pixels.
// Configuration registers reset to width 388, height 388, first sub-iteration.
module zhang_suen_thinning_pass_top #(
	parameter int MAX_WIDTH = zst_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [zst_pkg::IDX_W-1:0] cfg_index,
	input  logic [zst_pkg::CFG_W-1:0] cfg_data,
	zst_in_if.sink                    in_ch,
	zst_out_if.source                 out_ch
);
	logic                         accept;
	logic                         room;
	logic                         busy;
	logic                         push;
	logic [$clog2(MAX_WIDTH)-1:0] rd_col;
	zst_pkg::item_info_t          info;
	zst_pkg::result_t             res;

	assign in_ch.ready = room;
	assign accept      = in_ch.valid && room;

	zst_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.pixel_in   (in_ch.pixel_in),
		.is_padding (in_ch.is_padding),
		.rd_col     (rd_col),
		.info       (info)
	);

	zst_win #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.info   (info),
		.rd_col (rd_col),
		.busy   (busy),
		.push   (push),
		.res    (res)
	);

	zst_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.res     (res),
		.pending (busy),
		.room    (room),
		.out_ch  (out_ch)
	);
endmodule

// File: sv/zst_check.sv
// Port-level checker of the thinning pass, bound to the top level.
`include "zhang_suen_thinning_pass_top_assert.svh"

module zst_check (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic pixel_out,
	input logic was_removed,
	input logic last_of_frame,
	input logic frame_changed
);
	// A result offered and not taken is still offered next cycle.
	`ZST_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// The frame flag is only reported on the frame's final pixel.
	`ZST_ASSERT_IMP(a_changed_on_last, clk, arst_n, out_valid, !frame_changed || last_of_frame)
	// A cleared pixel always leaves as background.
	`ZST_ASSERT_IMP(a_removed_is_clear, clk, arst_n, out_valid && was_removed, !pixel_out)
	// With nothing waiting at the output, the input side never stalls.
	`ZST_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
endmodule

bind zhang_suen_thinning_pass_top zst_check u_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.pixel_out     (out_ch.pixel_out),
	.was_removed   (out_ch.was_removed),
	.last_of_frame (out_ch.last_of_frame),
	.frame_changed (out_ch.frame_changed)
);
